// ===== hdl/char_lcd_nibble_bus_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble bus sequencer
// Both macros sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_BUS_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_BUS_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication
`define LCDSEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LCDSEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, timing constants and the initialisation script of the LCD sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int HOLD_W   = 14;
  localparam int HOLD_MAX = 16383;
  typedef logic [HOLD_W-1:0] hold_t;

  // Initialisation group index (power-up wait, three reset nibbles, mode
  // nibble, function set, display on, clear, entry mode)
  localparam int GRP_W = 4;
  typedef logic [GRP_W-1:0] grp_t;

  localparam grp_t GRP_POWER      = 4'd0;
  localparam grp_t GRP_RESET_1    = 4'd1;
  localparam grp_t GRP_RESET_2    = 4'd2;
  localparam grp_t GRP_RESET_LAST = 4'd3;
  localparam grp_t GRP_MODE       = 4'd4;
  localparam grp_t GRP_FSET       = 4'd5;
  localparam grp_t GRP_DISP       = 4'd6;
  localparam grp_t GRP_CLR        = 4'd7;
  localparam grp_t GRP_ENTRY      = 4'd8;

  typedef enum logic [1:0] {
    OP_INIT       = 2'd0,
    OP_WR_INSTR   = 2'd1,
    OP_WR_DATA    = 2'd2,
    OP_SET_CURSOR = 2'd3
  } opcode_t;

  localparam logic [1:0] ROW_TOP    = 2'd1;
  localparam logic [1:0] ROW_BOTTOM = 2'd2;

  // Timing (us)
  localparam hold_t SETUP_US      = 14'd2;
  localparam hold_t PULSE_US      = 14'd2;
  localparam hold_t RESET_WAIT_US = 14'd5000;
  localparam hold_t MODE_WAIT_US  = 14'd40;
  localparam hold_t CLEAR_WAIT_US = 14'd2000;
  localparam hold_t RELEASE_US    = 14'd0;

  // Instruction bytes; single-nibble groups carry their nibble in the low half
  localparam logic [7:0] RESET_NIB   = 8'h03;
  localparam logic [7:0] MODE_NIB    = 8'h02;
  localparam logic [7:0] FS_TWO_LINE = 8'h28;
  localparam logic [7:0] FS_ONE_LINE = 8'h20;
  localparam logic [7:0] DISP_ON     = 8'h0F;
  localparam logic [7:0] CLEAR_DISP  = 8'h01;
  localparam logic [7:0] ENTRY_MODE  = 8'h06;
  localparam logic [7:0] ROW1_BASE   = 8'h80;
  localparam logic [7:0] ROW2_BASE   = 8'hC0;

  typedef enum logic [2:0] {
    PK_HI_SETUP,
    PK_HI_PULSE,
    PK_LO_SETUP,
    PK_LO_PULSE,
    PK_WAIT,
    PK_RELEASE
  } pin_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HI_SETUP,
    ST_HI_PULSE,
    ST_LO_SETUP,
    ST_LO_PULSE,
    ST_WAIT,
    ST_RELEASE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic      ready;
    logic      load;
    logic      next_grp;
    logic      emit;
    pin_kind_t kind;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_init;
    logic in_drop;
    logic out_free;
    logic grp_last;
    logic next_single;
  } dp_status_t;

  // Byte sent by an initialisation group
  function automatic logic [7:0] init_byte(grp_t g, logic two_line);
    logic [7:0] b;
    unique case (g)
      GRP_RESET_1, GRP_RESET_2, GRP_RESET_LAST: b = RESET_NIB;
      GRP_MODE:  b = MODE_NIB;
      GRP_FSET:  b = two_line ? FS_TWO_LINE : FS_ONE_LINE;
      GRP_DISP:  b = DISP_ON;
      GRP_CLR:   b = CLEAR_DISP;
      GRP_ENTRY: b = ENTRY_MODE;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/lcdseq_if.sv =====
// ----------------------------------------------------------------------------
// lcdseq interfaces
// Command channel and pin-state channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcdseq_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] value;
  logic [1:0] row;
  logic [5:0] column;

  modport source (output valid, opcode, value, row, column, input ready);
  modport sink   (input valid, opcode, value, row, column, output ready);
endinterface

interface lcdseq_pin_if import lcdseq_pkg::*;;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       read_write;
  logic       enable;
  logic [3:0] data_nibble;
  logic       bus_drive;
  hold_t      hold_us;
  logic       last;

  modport source (output valid, reg_select, read_write, enable, data_nibble,
                  bus_drive, hold_us, last, input ready);
  modport sink   (input valid, reg_select, read_write, enable, data_nibble,
                  bus_drive, hold_us, last, output ready);
endinterface

// ===== hdl/lcdseq_dp.sv =====
// ----------------------------------------------------------------------------
// lcdseq_dp
// Datapath: command registers, init group counter, pin-state formation and
// the output word register.
// ----------------------------------------------------------------------------
module lcdseq_dp import lcdseq_pkg::*; #(
  parameter int POWER_UP_WAIT_US = 15000,
  parameter int EXEC_WAIT_US     = 45
) (
  input  logic              clk,
  input  logic              rst,
  lcdseq_cmd_if.sink        cmd,
  lcdseq_pin_if.source      pin,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  ctrl_cmd_t         ctl,
  output dp_status_t        st
);

  // Hold times saturate to the field range
  localparam int    PU_SAT    = (POWER_UP_WAIT_US > HOLD_MAX) ? HOLD_MAX : POWER_UP_WAIT_US;
  localparam int    EXEC_SAT  = (EXEC_WAIT_US > HOLD_MAX) ? HOLD_MAX : EXEC_WAIT_US;
  localparam hold_t PU_HOLD   = hold_t'(PU_SAT);
  localparam hold_t EXEC_HOLD = hold_t'(EXEC_SAT);

  logic       two_line;
  logic       is_init;
  logic       rs_data;
  logic [7:0] wr_byte;
  grp_t       grp;

  logic [7:0] col_off;
  logic [7:0] cursor_byte;
  logic [7:0] cur_byte;
  hold_t      wait_hold;

  logic       p_rs;
  logic       p_en;
  logic [3:0] p_nib;
  logic       p_drive;
  hold_t      p_hold;
  logic       p_last;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      two_line <= 1'b1;
    end else if (cfg_we) begin
      two_line <= cfg_wdata;
    end
  end

  // Cursor address: base OR (column - 1), wrapping
  assign col_off     = {2'b00, cmd.column} - 8'd1;
  assign cursor_byte = ((cmd.row == ROW_TOP) ? ROW1_BASE : ROW2_BASE) | col_off;

  // Command registers and group counter
  always_ff @(posedge clk) begin
    if (rst) begin
      is_init <= 1'b0;
      grp     <= GRP_POWER;
    end else if (ctl.load) begin
      is_init <= (cmd.opcode == OP_INIT);
      grp     <= GRP_POWER;
    end else if (ctl.next_grp) begin
      grp     <= grp + grp_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rs_data <= (cmd.opcode == OP_WR_DATA);
      wr_byte <= (cmd.opcode == OP_SET_CURSOR) ? cursor_byte : cmd.value;
    end
  end

  assign cur_byte = is_init ? init_byte(grp, two_line) : wr_byte;

  // Wait time after the current byte or nibble
  always_comb begin
    if (!is_init) begin
      wait_hold = EXEC_HOLD;
    end else begin
      unique case (grp)
        GRP_POWER:                   wait_hold = PU_HOLD;
        GRP_MODE:                    wait_hold = MODE_WAIT_US;
        GRP_DISP, GRP_CLR, GRP_ENTRY: wait_hold = CLEAR_WAIT_US;
        default:                     wait_hold = RESET_WAIT_US;
      endcase
    end
  end

  // Pin state for the requested step
  always_comb begin
    p_rs    = 1'b0;
    p_en    = 1'b0;
    p_nib   = 4'h0;
    p_drive = 1'b1;
    p_hold  = SETUP_US;
    p_last  = 1'b0;
    unique case (ctl.kind)
      PK_HI_SETUP: begin
        p_rs  = rs_data;
        p_nib = cur_byte[7:4];
      end
      PK_HI_PULSE: begin
        p_rs   = rs_data;
        p_en   = 1'b1;
        p_nib  = cur_byte[7:4];
        p_hold = PULSE_US;
      end
      PK_LO_SETUP: begin
        p_rs  = rs_data;
        p_nib = cur_byte[3:0];
      end
      PK_LO_PULSE: begin
        p_rs   = rs_data;
        p_en   = 1'b1;
        p_nib  = cur_byte[3:0];
        p_hold = PULSE_US;
      end
      PK_WAIT: begin
        p_nib  = cur_byte[3:0];
        p_hold = wait_hold;
      end
      PK_RELEASE: begin
        p_drive = 1'b0;
        p_hold  = RELEASE_US;
        p_last  = 1'b1;
      end
      default: begin
        p_drive = 1'b0;
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      pin.valid <= 1'b0;
    end else if (ctl.emit) begin
      pin.valid <= 1'b1;
    end else if (pin.ready) begin
      pin.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pin.reg_select  <= p_rs;
      pin.read_write  <= 1'b0;
      pin.enable      <= p_en;
      pin.data_nibble <= p_nib;
      pin.bus_drive   <= p_drive;
      pin.hold_us     <= p_hold;
      pin.last        <= p_last;
    end
  end

  // Handshake and status
  assign cmd.ready      = ctl.ready;
  assign st.in_valid    = cmd.valid;
  assign st.in_init     = (cmd.opcode == OP_INIT);
  assign st.in_drop     = (cmd.opcode == OP_SET_CURSOR) &&
                          (cmd.row != ROW_TOP) && (cmd.row != ROW_BOTTOM);
  assign st.out_free    = !pin.valid || pin.ready;
  assign st.grp_last    = !is_init || (grp == GRP_ENTRY);
  assign st.next_single = is_init && (grp < GRP_MODE);

endmodule

// ===== hdl/lcdseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Controller: walks setup/pulse/wait steps for each byte or nibble and the
// final bus release, one word per cycle while the output register is free.
// ----------------------------------------------------------------------------
module lcdseq_ctrl import lcdseq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t st,
  output ctrl_cmd_t  ctl
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (st.in_valid && !st.in_drop) begin
          state_next = st.in_init ? ST_WAIT : ST_HI_SETUP;
        end
      end
      ST_HI_SETUP: if (st.out_free) state_next = ST_HI_PULSE;
      ST_HI_PULSE: if (st.out_free) state_next = ST_LO_SETUP;
      ST_LO_SETUP: if (st.out_free) state_next = ST_LO_PULSE;
      ST_LO_PULSE: if (st.out_free) state_next = ST_WAIT;
      ST_WAIT: begin
        if (st.out_free) begin
          priority if (st.grp_last) begin
            state_next = ST_RELEASE;
          end else if (st.next_single) begin
            state_next = ST_LO_SETUP;
          end else begin
            state_next = ST_HI_SETUP;
          end
        end
      end
      ST_RELEASE:  if (st.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl.ready    = 1'b0;
    ctl.load     = 1'b0;
    ctl.next_grp = 1'b0;
    ctl.emit     = 1'b0;
    ctl.kind     = PK_RELEASE;
    unique case (state)
      ST_IDLE: begin
        ctl.ready = 1'b1;
        ctl.load  = st.in_valid && !st.in_drop;
      end
      ST_HI_SETUP: begin
        ctl.emit = st.out_free;
        ctl.kind = PK_HI_SETUP;
      end
      ST_HI_PULSE: begin
        ctl.emit = st.out_free;
        ctl.kind = PK_HI_PULSE;
      end
      ST_LO_SETUP: begin
        ctl.emit = st.out_free;
        ctl.kind = PK_LO_SETUP;
      end
      ST_LO_PULSE: begin
        ctl.emit = st.out_free;
        ctl.kind = PK_LO_PULSE;
      end
      ST_WAIT: begin
        ctl.emit     = st.out_free;
        ctl.kind     = PK_WAIT;
        ctl.next_grp = st.out_free && !st.grp_last;
      end
      ST_RELEASE: begin
        ctl.emit = st.out_free;
        ctl.kind = PK_RELEASE;
      end
      default: begin
        ctl.emit = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/char_lcd_nibble_bus_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_sequencer_core
// Turns LCD commands into timed pin-state words for a 4-bit character bus.
//
//   channel  dir  payload                                            handshake
//   cmd      in   opcode, value, row, column                         valid/ready
//   pin      out  reg_select, read_write, enable, data_nibble,
//                 bus_drive, hold_us, last                           valid/ready
//   cfg      in   cfg_wdata (two_line_mode)                          cfg_we
//
// A command is taken, then one word per cycle while the pin channel accepts:
// 6 words for a write or cursor set, 34 for initialisation. A cursor set
// with row 0 or 3 is taken and gives no word.
// The controller steps once per cycle; a stalled pin channel holds it.
// Synchronous reset sets two_line_mode and empties the output register.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_bus_sequencer_core_macros.svh"

module char_lcd_nibble_bus_sequencer_core import lcdseq_pkg::*; #(
  parameter int POWER_UP_WAIT_US = 15000,
  parameter int EXEC_WAIT_US     = 45
) (
  input  logic          clk,
  input  logic          rst,
  lcdseq_cmd_if.sink    cmd,
  lcdseq_pin_if.source  pin,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  ctrl_cmd_t  ctl;
  dp_status_t st;

  // Controller
  lcdseq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  // Datapath
  lcdseq_dp #(
    .POWER_UP_WAIT_US (POWER_UP_WAIT_US),
    .EXEC_WAIT_US     (EXEC_WAIT_US)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pin       (pin),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .st        (st)
  );

  // Checks
  `LCDSEQ_ASSERT_IMP(a_pulse_driven, pin.valid && pin.enable, pin.bus_drive && !pin.last, "EN pulse with bus released or on last word")
  `LCDSEQ_ASSERT_IMP(a_last_released, pin.valid && pin.last, !pin.bus_drive && !pin.enable && (pin.hold_us == RELEASE_US), "last word does not release the bus")
  `LCDSEQ_ASSERT_NXT(a_busy_after_take, cmd.valid && cmd.ready && !st.in_drop, !cmd.ready, "new command taken while a run is in progress")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for char_lcd_nibble_bus_sequencer_core
// Sends LCD commands over the cmd channel and works out the pin-state words
// each one should produce with an in-bench model of the sequencer. Every word
// from the pin channel is compared field by field against the oldest
// prediction. Both sides idle at random, the receiver stalls long once, and
// the line mode register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import lcdseq_pkg::*;

  localparam int unsigned POWER_UP_US    = 15000;
  localparam int unsigned EXEC_US        = 45;
  localparam int unsigned NIB_SETUP_US   = 2;
  localparam int unsigned NIB_PULSE_US   = 2;
  localparam int unsigned WAKE_WAIT_US   = 5000;
  localparam int unsigned MODE_WAIT_US   = 40;
  localparam int unsigned SCRIPT_WAIT_US = 2000;
  localparam int unsigned HOLD_LIMIT     = 16383;

  localparam logic [3:0] WAKE_NIB      = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;
  localparam logic [7:0] FSET_2LINE    = 8'h28;
  localparam logic [7:0] FSET_1LINE    = 8'h20;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CURSOR_ROW1   = 8'h80;
  localparam logic [7:0] CURSOR_ROW2   = 8'hC0;

  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 55;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [3:0] data_nibble;
    logic       bus_drive;
    hold_t      hold_us;
    logic       last;
  } pin_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  lcdseq_cmd_if cmd_bus ();
  lcdseq_pin_if pin_bus ();

  char_lcd_nibble_bus_sequencer_core #(
    .POWER_UP_WAIT_US(POWER_UP_US),
    .EXEC_WAIT_US    (EXEC_US)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_bus),
    .pin      (pin_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Model state and scoreboard
  logic        line_mode_model;
  pin_word_t   expected_pins[$];
  int unsigned mismatch_count;
  int unsigned words_checked;
  int unsigned op_count[4];
  bit          line_mode_seen[2];

  // Traffic shaping flags
  bit src_no_gaps;
  bit sink_no_stalls;
  bit holdoff_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic rs, logic en, logic [3:0] nib, logic drive,
                            int unsigned hold, logic last);
    pin_word_t w;
    if (hold > HOLD_LIMIT) hold = HOLD_LIMIT;
    w.reg_select  = rs;
    w.read_write  = 1'b0;
    w.enable      = en;
    w.data_nibble = nib;
    w.bus_drive   = drive;
    w.hold_us     = hold_t'(hold);
    w.last        = last;
    expected_pins.push_back(w);
  endtask

  // setup with EN low, then the EN pulse
  task automatic queue_nibble(logic rs, logic [3:0] nib);
    queue_word(rs, 1'b0, nib, 1'b1, NIB_SETUP_US, 1'b0);
    queue_word(rs, 1'b1, nib, 1'b1, NIB_PULSE_US, 1'b0);
  endtask

  task automatic queue_octet(logic rs, logic [7:0] octet);
    queue_nibble(rs, octet[7:4]);
    queue_nibble(rs, octet[3:0]);
  endtask

  // byte, execution wait (RS always low), bus release
  task automatic queue_lcd_write(logic rs, logic [7:0] octet);
    queue_octet(rs, octet);
    queue_word(1'b0, 1'b0, octet[3:0], 1'b1, EXEC_US, 1'b0);
    queue_word(1'b0, 1'b0, 4'h0, 1'b0, 0, 1'b1);
  endtask

  task automatic predict_pin_words(opcode_t op, logic [7:0] value, logic [1:0] row,
                                   logic [5:0] column);
    logic [7:0] fset;
    logic [7:0] addr;
    logic [7:0] script [3];
    script = '{CMD_DISP_ON, CMD_CLEAR, CMD_ENTRY};
    case (op)
      OP_INIT: begin
        fset = line_mode_model ? FSET_2LINE : FSET_1LINE;
        line_mode_seen[line_mode_model] = 1'b1;
        queue_word(1'b0, 1'b0, 4'h0, 1'b1, POWER_UP_US, 1'b0);
        // three wake-up nibbles
        repeat (3) begin
          queue_nibble(1'b0, WAKE_NIB);
          queue_word(1'b0, 1'b0, WAKE_NIB, 1'b1, WAKE_WAIT_US, 1'b0);
        end
        // switch to 4-bit mode
        queue_nibble(1'b0, FOUR_BIT_NIB);
        queue_word(1'b0, 1'b0, FOUR_BIT_NIB, 1'b1, MODE_WAIT_US, 1'b0);
        queue_octet(1'b0, fset);
        queue_word(1'b0, 1'b0, fset[3:0], 1'b1, WAKE_WAIT_US, 1'b0);
        for (int i = 0; i < 3; i++) begin
          queue_octet(1'b0, script[i]);
          queue_word(1'b0, 1'b0, script[i][3:0], 1'b1, SCRIPT_WAIT_US, 1'b0);
        end
        queue_word(1'b0, 1'b0, 4'h0, 1'b0, 0, 1'b1);
      end
      OP_WR_INSTR: queue_lcd_write(1'b0, value);
      OP_WR_DATA:  queue_lcd_write(1'b1, value);
      default: begin
        // column counted from 1; column 0 wraps to 0xFF
        addr = {2'b00, column} - 8'd1;
        if (row == ROW_TOP) begin
          queue_lcd_write(1'b0, CURSOR_ROW1 | addr);
        end else if (row == ROW_BOTTOM) begin
          queue_lcd_write(1'b0, CURSOR_ROW2 | addr);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // valid stays high between back-to-back words; it is dropped only for a gap
  task automatic send_command(opcode_t op, logic [7:0] value, logic [1:0] row,
                              logic [5:0] column);
    int unsigned gap;
    gap = src_no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid  <= 1'b1;
    cmd_bus.opcode <= op;
    cmd_bus.value  <= value;
    cmd_bus.row    <= row;
    cmd_bus.column <= column;
    do @(posedge clk); while (!cmd_bus.ready);
    predict_pin_words(op, value, row, column);
    op_count[op]++;
  endtask

  task automatic send_random_command();
    int unsigned pick;
    opcode_t     op;
    logic [1:0]  row;
    logic [5:0]  column;
    pick = $urandom_range(0, 99);
    if (pick < 5)       op = OP_INIT;
    else if (pick < 35) op = OP_WR_INSTR;
    else if (pick < 70) op = OP_WR_DATA;
    else                op = OP_SET_CURSOR;
    // mostly a real row and column, now and then anything the fields allow
    row    = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
    column = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(1, 40));
    send_command(op, 8'($urandom), row, column);
  endtask

  // Stop offering and wait for every predicted word, then let a dropped
  // cursor set finish
  task automatic wait_pins_drained();
    cmd_bus.valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_mode(logic mode);
    wait_pins_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    line_mode_model = mode;
  endtask

  // ---------------------------------------------------------------------------
  // Pin side: random stalls, one long hold-off on request, field checks
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin : pin_sink
    int unsigned stall;
    pin_word_t   want;
    pin_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        pin_bus.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      stall = sink_no_stalls ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        pin_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pin_bus.ready <= 1'b1;
      do @(posedge clk); while (!(pin_bus.valid && pin_bus.ready));
      if (expected_pins.size() == 0) begin
        mismatch_count++;
        $display("%0t: pin word with nothing expected", $time);
      end else begin
        want = expected_pins.pop_front();
        words_checked++;
        check_field("reg_select",  want.reg_select,  pin_bus.reg_select);
        check_field("read_write",  want.read_write,  pin_bus.read_write);
        check_field("enable",      want.enable,      pin_bus.enable);
        check_field("data_nibble", want.data_nibble, pin_bus.data_nibble);
        check_field("bus_drive",   want.bus_drive,   pin_bus.bus_drive);
        check_field("hold_us",     want.hold_us,     pin_bus.hold_us);
        check_field("last",        want.last,        pin_bus.last);
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst === 1'b0);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (pin_bus.valid && pin_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // init in the reset line mode, then in each mode written explicitly
  task automatic test_line_modes();
    send_command(OP_INIT, 8'h00, 2'd0, 6'd0);
    write_line_mode(1'b0);
    send_command(OP_INIT, 8'hFF, 2'd3, 6'd63);
    write_line_mode(1'b1);
    send_command(OP_INIT, 8'h5A, 2'd1, 6'd1);
  endtask

  task automatic test_byte_writes();
    send_command(OP_WR_INSTR, 8'h00, 2'd0, 6'd0);
    send_command(OP_WR_INSTR, 8'hFF, 2'd3, 6'd63);
    send_command(OP_WR_INSTR, 8'hA5, 2'd1, 6'd20);
    send_command(OP_WR_DATA,  8'h00, 2'd0, 6'd0);
    send_command(OP_WR_DATA,  8'hFF, 2'd3, 6'd63);
    send_command(OP_WR_DATA,  8'h5A, 2'd2, 6'd40);
  endtask

  // both rows at the column ends, rows that do nothing, wrapping columns
  task automatic test_cursor_moves();
    send_command(OP_SET_CURSOR, 8'h00, 2'd1, 6'd1);
    send_command(OP_SET_CURSOR, 8'hFF, 2'd1, 6'd40);
    send_command(OP_SET_CURSOR, 8'h00, 2'd2, 6'd1);
    send_command(OP_SET_CURSOR, 8'hFF, 2'd2, 6'd40);
    send_command(OP_SET_CURSOR, 8'h00, 2'd0, 6'd5);
    send_command(OP_SET_CURSOR, 8'hFF, 2'd3, 6'd5);
    send_command(OP_SET_CURSOR, 8'h00, 2'd1, 6'd0);
    send_command(OP_SET_CURSOR, 8'hFF, 2'd2, 6'd63);
    send_command(OP_SET_CURSOR, 8'h00, 2'd3, 6'd0);
  endtask

  // phases of random traffic, line mode rewritten between them
  task automatic test_random_traffic();
    logic mode;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_line_mode(mode);
      repeat (PHASE_ITEMS) send_random_command();
    end
  endtask

  // receiver holds off while commands keep coming, then the sender drains
  task automatic test_backpressure();
    src_no_gaps = 1'b1;
    holdoff_req = 1'b1;
    repeat (24) send_random_command();
    src_no_gaps = 1'b0;
    wait_pins_drained();
  endtask

  task automatic test_full_rate();
    src_no_gaps    = 1'b1;
    sink_no_stalls = 1'b1;
    repeat (40) send_random_command();
    src_no_gaps    = 1'b0;
    sink_no_stalls = 1'b0;
    wait_pins_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    cmd_bus.valid  <= 1'b0;
    cmd_bus.opcode <= OP_INIT;
    cmd_bus.value  <= 8'h00;
    cmd_bus.row    <= 2'd0;
    cmd_bus.column <= 6'd0;
    line_mode_model = 1'b1;
    mismatch_count  = 0;
    words_checked   = 0;
    op_count        = '{default: 0};
    line_mode_seen  = '{default: 1'b0};
    src_no_gaps     = 1'b0;
    sink_no_stalls  = 1'b0;
    holdoff_req     = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_line_modes();
    test_byte_writes();
    test_cursor_moves();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    wait_pins_drained();

    $display("Covered %0d init, %0d instruction, %0d data, %0d cursor commands;",
             op_count[OP_INIT], op_count[OP_WR_INSTR], op_count[OP_WR_DATA],
             op_count[OP_SET_CURSOR]);
    $display("%0d pin words compared, init seen in one-line %0b / two-line %0b, %0d mismatches",
             words_checked, line_mode_seen[0], line_mode_seen[1], mismatch_count);
    if (mismatch_count == 0 && expected_pins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
